// ===== hw/rtl/yuv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// yuv2rgb_pkg
// constants, widths and arithmetic helpers for the yuyv to rgb888 converter
// ----------------------------------------------------------------------------
package yuv2rgb_pkg;

    // field widths
    localparam int unsigned SampleW  = 8;
    localparam int unsigned OffsetW  = SampleW + 1;      // signed chroma offset
    localparam int unsigned CoefW    = 17;               // unsigned q.16 coefficients
    localparam int unsigned FracBits = 16;
    localparam int unsigned ProdW    = CoefW + OffsetW;  // signed product
    localparam int unsigned AccW     = 28;               // signed channel sum

    localparam int unsigned InDataW  = 4 * SampleW;
    localparam int unsigned OutDataW = 6 * SampleW;

    // q.16 coefficients, rounded to nearest
    localparam logic [CoefW-1:0] CoefRCr = 17'd92176;
    localparam logic [CoefW-1:0] CoefGCb = 17'd22643;
    localparam logic [CoefW-1:0] CoefGCr = 17'd46983;
    localparam logic [CoefW-1:0] CoefBCb = 17'd116589;

    localparam logic [SampleW-1:0] ChromaMid = 8'd128;
    localparam logic [SampleW-1:0] ChanMax   = 8'd255;

    // top of the channel range in q.16
    localparam logic signed [AccW-1:0] ChanTop =
        AccW'(signed'({1'b0, ChanMax, {FracBits{1'b0}}}));

    typedef logic signed [OffsetW-1:0] offset_t;
    typedef logic signed [ProdW-1:0]   prod_t;
    typedef logic signed [AccW-1:0]    acc_t;
    typedef logic [SampleW-1:0]        sample_t;

    // chroma sample minus 128
    function automatic offset_t chroma_offset(input sample_t c);
        offset_t r;
        r = offset_t'({1'b0, c}) - offset_t'({1'b0, ChromaMid});
        return r;
    endfunction

    // unsigned coefficient times signed offset
    function automatic prod_t coef_mul(input logic [CoefW-1:0] coef, input offset_t off);
        logic signed [CoefW:0] c;
        prod_t                 p;
        c = signed'({1'b0, coef});
        // both operands widened to the product width before the multiply
        p = prod_t'(c) * prod_t'(off);
        return p;
    endfunction

    // luma scaled to q.16, zero-extended to accumulator width
    function automatic acc_t luma_base(input sample_t y);
        acc_t r;
        r = acc_t'({4'b0, y, {FracBits{1'b0}}});
        return r;
    endfunction

    // saturate to 0..255 and drop the fraction
    function automatic sample_t clamp_channel(input acc_t acc);
        sample_t r;
        if (acc <= 0) begin
            r = '0;
        end else if (acc >= ChanTop) begin
            r = ChanMax;
        end else begin
            r = acc[FracBits +: SampleW];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/yuyv_to_rgb_pixel_pair_top.sv =====
// ----------------------------------------------------------------------------
// yuyv_to_rgb_pixel_pair_top
// converts one packed yuyv word into two rgb888 pixels
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one yuyv word per request, m_ channel returns one
//   pair of rgb888 pixels per request, in the same order
//   each channel is luma plus or minus fixed q.16 multiples of (chroma - 128),
//   saturated to 0..255 with the fraction truncated
// path: each request passes four register stages: offset, multiply, sum, clamp
// throughput: one request per cycle while m_tready is high, set by the four
//   register stages; each stage holds one item and moves when the next frees up
// reset: aresetn low clears every stage valid bit, so no result is shown;
//   the arithmetic itself holds no state
// stall: with m_tready low the output stage holds its result, the stages
//   behind it keep filling any empty slot, and s_tready falls only when all
//   four stages are full; nothing is dropped or repeated
// ----------------------------------------------------------------------------
module yuyv_to_rgb_pixel_pair_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // luma_first, chroma_blue, luma_second, chroma_red
    input  logic [yuv2rgb_pkg::InDataW-1:0]   s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // red_first, green_first, blue_first, red_second, green_second, blue_second
    output logic [yuv2rgb_pkg::OutDataW-1:0]  m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready
);

    // stage 1: luma samples and chroma offsets
    logic                       v1_reg;
    yuv2rgb_pkg::sample_t       y0_1_reg, y1_1_reg;
    yuv2rgb_pkg::offset_t       cb_1_reg, cr_1_reg;

    // stage 2: coefficient products
    logic                       v2_reg;
    yuv2rgb_pkg::sample_t       y0_2_reg, y1_2_reg;
    yuv2rgb_pkg::prod_t         p_rcr_reg, p_gcb_reg, p_gcr_reg, p_bcb_reg;
    yuv2rgb_pkg::prod_t         p_rcr_next, p_gcb_next, p_gcr_next, p_bcb_next;

    // stage 3: channel sums in q.16
    logic                       v3_reg;
    yuv2rgb_pkg::acc_t          r0_reg, g0_reg, b0_reg, r1_reg, g1_reg, b1_reg;
    yuv2rgb_pkg::acc_t          r0_next, g0_next, b0_next, r1_next, g1_next, b1_next;
    yuv2rgb_pkg::acc_t          chroma_g_sum;

    // stage 4: clamped output register
    logic                       v4_reg;
    logic [yuv2rgb_pkg::OutDataW-1:0] out_reg, out_next;

    // each stage loads when empty or when the stage after it moves on
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    assign m_tvalid = v4_reg;
    assign m_tdata  = out_reg;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // multiplies, one per coefficient, shared by both pixels
    always_comb begin
        p_rcr_next = yuv2rgb_pkg::coef_mul(yuv2rgb_pkg::CoefRCr, cr_1_reg);
        p_gcb_next = yuv2rgb_pkg::coef_mul(yuv2rgb_pkg::CoefGCb, cb_1_reg);
        p_gcr_next = yuv2rgb_pkg::coef_mul(yuv2rgb_pkg::CoefGCr, cr_1_reg);
        p_bcb_next = yuv2rgb_pkg::coef_mul(yuv2rgb_pkg::CoefBCb, cb_1_reg);
    end

    // channel sums
    always_comb begin
        chroma_g_sum = yuv2rgb_pkg::acc_t'(p_gcb_reg) + yuv2rgb_pkg::acc_t'(p_gcr_reg);
        r0_next = yuv2rgb_pkg::luma_base(y0_2_reg) + yuv2rgb_pkg::acc_t'(p_rcr_reg);
        g0_next = yuv2rgb_pkg::luma_base(y0_2_reg) - chroma_g_sum;
        b0_next = yuv2rgb_pkg::luma_base(y0_2_reg) + yuv2rgb_pkg::acc_t'(p_bcb_reg);
        r1_next = yuv2rgb_pkg::luma_base(y1_2_reg) + yuv2rgb_pkg::acc_t'(p_rcr_reg);
        g1_next = yuv2rgb_pkg::luma_base(y1_2_reg) - chroma_g_sum;
        b1_next = yuv2rgb_pkg::luma_base(y1_2_reg) + yuv2rgb_pkg::acc_t'(p_bcb_reg);
    end

    // saturate and pack, red of the first pixel lowest
    always_comb begin
        out_next = {yuv2rgb_pkg::clamp_channel(b1_reg),
                    yuv2rgb_pkg::clamp_channel(g1_reg),
                    yuv2rgb_pkg::clamp_channel(r1_reg),
                    yuv2rgb_pkg::clamp_channel(b0_reg),
                    yuv2rgb_pkg::clamp_channel(g0_reg),
                    yuv2rgb_pkg::clamp_channel(r0_reg)};
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            y0_1_reg <= s_tdata[0 +: yuv2rgb_pkg::SampleW];
            cb_1_reg <= yuv2rgb_pkg::chroma_offset(
                            s_tdata[yuv2rgb_pkg::SampleW +: yuv2rgb_pkg::SampleW]);
            y1_1_reg <= s_tdata[2*yuv2rgb_pkg::SampleW +: yuv2rgb_pkg::SampleW];
            cr_1_reg <= yuv2rgb_pkg::chroma_offset(
                            s_tdata[3*yuv2rgb_pkg::SampleW +: yuv2rgb_pkg::SampleW]);
        end
        if (rdy2) begin
            y0_2_reg  <= y0_1_reg;
            y1_2_reg  <= y1_1_reg;
            p_rcr_reg <= p_rcr_next;
            p_gcb_reg <= p_gcb_next;
            p_gcr_reg <= p_gcr_next;
            p_bcb_reg <= p_bcb_next;
        end
        if (rdy3) begin
            r0_reg <= r0_next;
            g0_reg <= g0_next;
            b0_reg <= b0_next;
            r1_reg <= r1_next;
            g1_reg <= g1_next;
            b1_reg <= b1_next;
        end
        if (rdy4) begin
            out_reg <= out_next;
        end
    end

`ifndef ASSERT_OFF
    // a free output lets the whole chain take a new request
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output side is ready");

    // an item in stage 1 moves into stage 2 when stage 2 opens
    a_stage_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && rdy2) |=> v2_reg)
        else $error("item lost between stage 1 and stage 2");

    // a held result keeps the sum stage from overwriting it
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && !m_tready) |=> (v4_reg && $stable(out_reg)))
        else $error("stalled result changed");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!v1_reg && !v2_reg && !v3_reg && !m_tvalid))
        else $error("valid bit survived reset");
`endif

endmodule
